// ===== sv/piecewise_linear_feedforward_unit_defines.svh =====
// Assertion macros for the piecewise-linear feedforward unit.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef PIECEWISE_LINEAR_FEEDFORWARD_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_FEEDFORWARD_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PLFF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plff port check failed");

// Antecedent implies consequent in the following cycle.
`define PLFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plff port check failed");

`endif

// ===== sv/plff_pkg.sv =====
// Shared types and constants for the piecewise-linear feedforward unit.
// No dependencies; every other file but the assertion macro header imports it.
package plff_pkg;

    localparam int MAX_POINTS_DEFAULT = 16;
    localparam int DATA_W      = 16;
    localparam int INDEX_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;

    // Serial divider geometry: product magnitude over a positive temperature span
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [DATA_W-1:0] PWM_FLOOR_RESET   = 16'sd0;
    localparam logic signed [DATA_W-1:0] PWM_CEILING_RESET = 16'sd1000;

    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP = 3'd0,
        ST_BELOW  = 3'd1,
        ST_ABOVE  = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_NOSEG  = 3'd4,
        ST_LOADED = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POINT_COUNT = 2'd0,
        CFG_PWM_FLOOR   = 2'd1,
        CFG_PWM_CEILING = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic        [COUNT_W-1:0] point_count;
        logic signed [DATA_W-1:0]  pwm_floor;
        logic signed [DATA_W-1:0]  pwm_ceiling;
    } cfg_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_FIRST,
        RD_SECOND,
        RD_LAST,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_LOADED,
        RES_EMPTY,
        RES_BELOW,
        RES_ABOVE,
        RES_NOSEG,
        RES_CLAMP
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        rd_sel_t  rd_sel;
        logic     save_prev;
        logic     mul_en;
        logic     div_start;
        logic     sum_en;
        logic     val_from_prev;
        res_sel_t res_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;
        logic empty;
        logic le_cur;
        logic ge_cur;
        logic ge_prev;
        logic temps_equal;
        logic idx_last;
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/plff_in_if.sv =====
// Input channel of the feedforward unit: valid/ready plus one command beat.
// Depends on plff_pkg.
interface plff_in_if;
    import plff_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      command;
    logic        [INDEX_W-1:0] point_index;
    logic signed [DATA_W-1:0]  point_temperature;
    logic signed [DATA_W-1:0]  point_pwm;
    logic signed [DATA_W-1:0]  setpoint;

    modport source (
        output valid, command, point_index, point_temperature, point_pwm, setpoint,
        input  ready
    );

    modport sink (
        input  valid, command, point_index, point_temperature, point_pwm, setpoint,
        output ready
    );
endinterface

// ===== sv/plff_out_if.sv =====
// Output channel of the feedforward unit: valid/ready plus one result beat.
// Depends on plff_pkg.
interface plff_out_if;
    import plff_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   pwm;
    logic        [STATUS_W-1:0] status;

    modport source (
        output valid, pwm, status,
        input  ready
    );

    modport sink (
        input  valid, pwm, status,
        output ready
    );
endinterface

// ===== sv/plff_cfg.sv =====
// Configuration register file: point count and PWM clamp limits.
// Depends on plff_pkg.
module plff_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [plff_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [plff_pkg::DATA_W-1:0]         cfg_data,
    output plff_pkg::cfg_t                      cfg
);
    import plff_pkg::*;

    cfg_t cfg_reg;

    // Take a write; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.point_count <= '0;
            cfg_reg.pwm_floor   <= PWM_FLOOR_RESET;
            cfg_reg.pwm_ceiling <= PWM_CEILING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINT_COUNT: cfg_reg.point_count <= cfg_data[COUNT_W-1:0];
                CFG_PWM_FLOOR:   cfg_reg.pwm_floor   <= $signed(cfg_data);
                CFG_PWM_CEILING: cfg_reg.pwm_ceiling <= $signed(cfg_data);
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== sv/plff_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on plff_pkg.
module plff_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [plff_pkg::DIV_N_W-1:0]    dividend,
    input  logic [plff_pkg::DIV_D_W-1:0]    divisor,
    output logic                            done,
    output logic [plff_pkg::DIV_N_W-1:0]    quotient
);
    import plff_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W:0]   rem_shift;
    logic               fits;
    logic [DIV_D_W:0]   rem_diff;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_N_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Shift in one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done     = busy_reg && (cnt_reg == CNT_W'(DIV_N_W - 1));
    assign quotient = quo_reg;
endmodule

// ===== sv/plff_ctrl.sv =====
// Sequencer for load and evaluate commands: table scan, divide, clamp, hand-off.
// Depends on plff_pkg; drives the datapath through dp_cmd_t.
module plff_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  plff_pkg::dp_status_t    sts,
    output plff_pkg::dp_cmd_t       cmd
);
    import plff_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_SUM,
        S_CLAMP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_NONE;
        cmd.res_sel    = RES_NONE;

        // Drop the result once the sink takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_load)
                begin
                    cmd.res_sel = RES_LOADED;
                    state_next  = S_FINISH;
                end
                else if (sts.empty)
                begin
                    cmd.res_sel = RES_EMPTY;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_FIRST;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (sts.le_cur)
                begin
                    cmd.res_sel = RES_BELOW;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.rd_sel    = RD_LAST;
                    state_next    = S_LAST;
                end
            end
            S_LAST:
            begin
                if (sts.ge_cur)
                begin
                    cmd.res_sel = RES_ABOVE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_SECOND;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.ge_prev && sts.le_cur)
                begin
                    if (sts.temps_equal)
                    begin
                        cmd.val_from_prev = 1'b1;
                        state_next        = S_CLAMP;
                    end
                    else
                    begin
                        cmd.mul_en = 1'b1;
                        state_next = S_MUL;
                    end
                end
                else if (sts.idx_last)
                begin
                    cmd.res_sel = RES_NOSEG;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                end
            end
            S_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.res_sel = RES_CLAMP;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                // Hold until the output register is free or being emptied
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

// ===== sv/plff_dp.sv =====
// Datapath: breakpoint memory, segment compare, multiply, serial divide, clamp.
// Depends on plff_pkg and plff_div; steered by plff_ctrl through dp_cmd_t.
module plff_dp #(
    parameter int MAX_POINTS = plff_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plff_pkg::dp_cmd_t                   cmd,
    output plff_pkg::dp_status_t                sts,
    input  plff_pkg::cfg_t                      cfg,
    input  logic                                command,
    input  logic [plff_pkg::INDEX_W-1:0]        point_index,
    input  logic signed [plff_pkg::DATA_W-1:0]  point_temperature,
    input  logic signed [plff_pkg::DATA_W-1:0]  point_pwm,
    input  logic signed [plff_pkg::DATA_W-1:0]  setpoint,
    output logic signed [plff_pkg::DATA_W-1:0]  pwm,
    output logic [plff_pkg::STATUS_W-1:0]       status
);
    import plff_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = 2 * DATA_W;

    // Breakpoint memory: temperature in the upper half, PWM in the lower
    logic [EW-1:0] mem [MAX_POINTS];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;

    logic                       load_reg;
    logic signed [DATA_W-1:0]   sv_reg;
    logic signed [DATA_W-1:0]   prev_t_reg;
    logic signed [DATA_W-1:0]   prev_p_reg;
    logic signed [DATA_W-1:0]   cur_t;
    logic signed [DATA_W-1:0]   cur_p;

    logic [CW-1:0]  n_eff;
    logic [AW-1:0]  last_idx;

    logic signed [DATA_W:0]     dx;
    logic signed [DATA_W:0]     dy;
    logic signed [DATA_W:0]     span;
    logic signed [2*DATA_W+1:0] prod_reg;
    logic [2*DATA_W+1:0]        prod_mag;
    logic [DIV_D_W-1:0]         span_reg;
    logic                       neg_reg;

    logic                       div_done;
    logic [DIV_N_W-1:0]         quo;
    logic signed [DATA_W:0]     q_mag;
    logic signed [DATA_W+1:0]   val_reg;
    logic signed [DATA_W+1:0]   floor_ext;
    logic signed [DATA_W+1:0]   ceil_ext;
    logic signed [DATA_W-1:0]   clamped;

    logic signed [DATA_W-1:0]   res_pwm_reg;
    logic [STATUS_W-1:0]        res_status_reg;
    logic signed [DATA_W-1:0]   out_pwm_reg;
    logic [STATUS_W-1:0]        out_status_reg;

    // Points in use, limited to the table depth
    always_comb
    begin
        if (int'(cfg.point_count) > MAX_POINTS)
        begin
            n_eff = CW'(MAX_POINTS);
        end
        else
        begin
            n_eff = CW'(cfg.point_count);
        end
        last_idx = AW'(n_eff - CW'(1));
    end

    assign wr_ok   = (int'(point_index) < MAX_POINTS);
    assign wr_addr = AW'(point_index);

    // Read address for the next table access
    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST:  rd_addr = '0;
            RD_SECOND: rd_addr = AW'(1);
            RD_LAST:   rd_addr = last_idx;
            RD_NEXT:   rd_addr = idx_reg + AW'(1);
            default:   rd_addr = idx_reg;
        endcase
    end

    // Write a breakpoint on an accepted load beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture && (command == CMD_LOAD) && wr_ok)
        begin
            mem[wr_addr] <= {point_temperature, point_pwm};
        end
    end

    // Registered table read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_sel != RD_NONE)
        begin
            rd_data_reg <= mem[rd_addr];
            idx_reg     <= rd_addr;
        end
    end

    assign cur_t = $signed(rd_data_reg[EW-1:DATA_W]);
    assign cur_p = $signed(rd_data_reg[DATA_W-1:0]);

    // Latch the beat and the lower end of the current segment
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            load_reg <= (command == CMD_LOAD);
            sv_reg   <= setpoint;
        end
        if (cmd.save_prev)
        begin
            prev_t_reg <= cur_t;
            prev_p_reg <= cur_p;
        end
    end

    // Segment deltas; dx and span are never negative on a bracketing segment
    always_comb
    begin
        dx   = (DATA_W+1)'(sv_reg) - (DATA_W+1)'(prev_t_reg);
        dy   = (DATA_W+1)'(cur_p) - (DATA_W+1)'(prev_p_reg);
        span = (DATA_W+1)'(cur_t) - (DATA_W+1)'(prev_t_reg);
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= dx * dy;
            span_reg <= span[DIV_D_W-1:0];
            neg_reg  <= dy[DATA_W];
        end
    end

    assign prod_mag = neg_reg ? -prod_reg : prod_reg;

    plff_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_mag[DIV_N_W-1:0]),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Quotient never exceeds the PWM step, so its low half is the whole value
    assign q_mag = $signed({1'b0, quo[DATA_W-1:0]});

    // Restore sign, add the segment base, or pass the base through for a flat step
    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            val_reg <= (neg_reg ? -(DATA_W+2)'(q_mag) : (DATA_W+2)'(q_mag))
                       + (DATA_W+2)'(prev_p_reg);
        end
        else if (cmd.val_from_prev)
        begin
            val_reg <= (DATA_W+2)'(prev_p_reg);
        end
    end

    // Clamp, floor first
    always_comb
    begin
        floor_ext = (DATA_W+2)'(cfg.pwm_floor);
        ceil_ext  = (DATA_W+2)'(cfg.pwm_ceiling);
        if (val_reg < floor_ext)
        begin
            clamped = cfg.pwm_floor;
        end
        else if (val_reg > ceil_ext)
        begin
            clamped = cfg.pwm_ceiling;
        end
        else
        begin
            clamped = val_reg[DATA_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        case (cmd.res_sel)
            RES_LOADED:
            begin
                res_pwm_reg    <= '0;
                res_status_reg <= ST_LOADED;
            end
            RES_EMPTY:
            begin
                res_pwm_reg    <= '0;
                res_status_reg <= ST_EMPTY;
            end
            RES_BELOW:
            begin
                res_pwm_reg    <= cur_p;
                res_status_reg <= ST_BELOW;
            end
            RES_ABOVE:
            begin
                res_pwm_reg    <= cur_p;
                res_status_reg <= ST_ABOVE;
            end
            RES_NOSEG:
            begin
                res_pwm_reg    <= '0;
                res_status_reg <= ST_NOSEG;
            end
            RES_CLAMP:
            begin
                res_pwm_reg    <= clamped;
                res_status_reg <= ST_INTERP;
            end
            default:
            begin
                res_pwm_reg    <= res_pwm_reg;
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pwm_reg    <= res_pwm_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign pwm    = out_pwm_reg;
    assign status = out_status_reg;

    // Status back to the sequencer
    always_comb
    begin
        sts.is_load     = load_reg;
        sts.empty       = (n_eff == '0);
        sts.le_cur      = (sv_reg <= cur_t);
        sts.ge_cur      = (sv_reg >= cur_t);
        sts.ge_prev     = (sv_reg >= prev_t_reg);
        sts.temps_equal = (prev_t_reg == cur_t);
        sts.idx_last    = (idx_reg == last_idx);
        sts.div_done    = div_done;
    end
endmodule

// ===== sv/piecewise_linear_feedforward_unit.sv =====
// Top level of the piecewise-linear feedforward unit.
// Depends on plff_pkg, plff_in_if, plff_out_if, plff_cfg, plff_ctrl, plff_dp.
//
//   Port     Direction  Handshake         Carries
//   in_ch    sink       valid/ready       load point or evaluate setpoint
//   out_ch   source     valid/ready       pwm and status, one per input beat
//   cfg_*    sink       cfg_we only       point_count, pwm_floor, pwm_ceiling
//
// One beat at a time. A load goes from decode straight to the hand-off.
// An evaluate skips the scan and the divider when it falls outside the table or the
// table is empty; when it interpolates over n points it makes one read per segment
// through the single table read port, then runs the serial divider.
// Reset clears the sequencer and configuration; the table keeps no reset value.
// A result waits in the output register while the next beat is taken.
module piecewise_linear_feedforward_unit #(
    parameter int MAX_POINTS = plff_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [plff_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [plff_pkg::DATA_W-1:0]         cfg_data,
    plff_in_if.sink                             in_ch,
    plff_out_if.source                          out_ch
);
    import plff_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t sts;

    plff_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    plff_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg               (cfg),
        .command           (in_ch.command),
        .point_index       (in_ch.point_index),
        .point_temperature (in_ch.point_temperature),
        .point_pwm         (in_ch.point_pwm),
        .setpoint          (in_ch.setpoint),
        .pwm               (out_ch.pwm),
        .status            (out_ch.status)
    );
endmodule

// ===== sv/plff_checker.sv =====
// Port-level checks for the feedforward unit, bound to the top level.
// Depends on plff_pkg and piecewise_linear_feedforward_unit_defines.svh.
`include "piecewise_linear_feedforward_unit_defines.svh"

module plff_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [plff_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [plff_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [plff_pkg::DATA_W-1:0]  out_pwm,
    input  logic [plff_pkg::STATUS_W-1:0]       out_status
);
    import plff_pkg::*;

    logic signed [DATA_W-1:0] floor_reg;
    logic signed [DATA_W-1:0] ceil_reg;
    logic                     out_stalled;
    logic                     zero_status;
    logic                     interp_ordered;

    // Shadow the clamp limits from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= PWM_FLOOR_RESET;
            ceil_reg  <= PWM_CEILING_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PWM_FLOOR)
            begin
                floor_reg <= $signed(cfg_data);
            end
            if (cfg_index == CFG_PWM_CEILING)
            begin
                ceil_reg <= $signed(cfg_data);
            end
        end
    end

    // Conditions watched by the checks below
    assign out_stalled    = out_valid && !out_ready;
    assign zero_status    = (out_status == ST_LOADED) || (out_status == ST_EMPTY) ||
                            (out_status == ST_NOSEG);
    assign interp_ordered = out_valid && (out_status == ST_INTERP) && (floor_reg <= ceil_reg);

    // A stalled result holds
    `PLFF_ASSERT_NEXT(a_out_hold, out_stalled, out_valid && $stable({out_pwm, out_status}))

    // One beat in flight: the input closes right after an accepted beat
    `PLFF_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // Loads, empty tables and unmatched setpoints drive zero
    `PLFF_ASSERT_NOW(a_zero_pwm, out_valid && zero_status, out_pwm == '0)

    // Interpolated results sit inside ordered limits
    `PLFF_ASSERT_NOW(a_clamped, interp_ordered, out_pwm >= floor_reg && out_pwm <= ceil_reg)
endmodule

bind piecewise_linear_feedforward_unit plff_checker u_plff_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pwm    (out_ch.pwm),
    .out_status (out_ch.status)
);

// ===== test/piecewise_linear_feedforward_unit_tb.sv =====
// Testbench for the piecewise-linear feedforward unit: table loads, evaluations and
// limit registers, checked beat by beat against a behavioural predictor.
// Depends on plff_pkg, plff_in_if, plff_out_if and piecewise_linear_feedforward_unit.
module piecewise_linear_feedforward_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plff_pkg::*;

    localparam int TABLE_SLOTS = MAX_POINTS_DEFAULT;
    localparam int TAIL_CYCLES = 60;

    typedef enum {JOB_BEAT, JOB_CFG} job_kind_t;

    typedef struct {
        logic                      command;
        logic        [INDEX_W-1:0] idx;
        logic signed [DATA_W-1:0]  temp;
        logic signed [DATA_W-1:0]  pwm;
        logic signed [DATA_W-1:0]  sp;
    } beat_t;

    typedef struct {
        job_kind_t          kind;
        beat_t              beat;
        cfg_index_t         reg_sel;
        logic [DATA_W-1:0]  data;
        int                 gap;
    } job_t;

    typedef struct {
        logic signed [DATA_W-1:0] pwm;
        status_t                  status;
    } drive_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    plff_in_if  in_ch();
    plff_out_if out_ch();

    piecewise_linear_feedforward_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the table and registers
    logic signed [DATA_W-1:0]  tab_temp [TABLE_SLOTS];
    logic signed [DATA_W-1:0]  tab_pwm  [TABLE_SLOTS];
    logic        [COUNT_W-1:0] used_points = '0;
    logic signed [DATA_W-1:0]  floor_lim   = PWM_FLOOR_RESET;
    logic signed [DATA_W-1:0]  ceil_lim    = PWM_CEILING_RESET;

    drive_t expected_drive [$];
    job_t   pending_jobs   [$];

    // Stimulus planning view of the table, kept at queue-fill time
    int plan_temp [TABLE_SLOTS];
    int plan_points;
    bit calm_sender;

    int beats_queued;
    int beats_accepted;
    int results_seen;
    int cfg_writes;
    int mismatches;
    int status_hits [6];

    bit in_took;
    bit out_took;
    bit job_active;
    job_t cur_job;
    int hold_left;
    int stall_left;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Work out the drive value and status for one accepted beat
    function automatic void predict_drive(input beat_t b, output logic signed [DATA_W-1:0] p,
                                          output status_t s);
        int     n;
        longint sv, x1, x2, y1, y2, v;
        bit     hit;
        p = '0;
        if (b.command == CMD_LOAD)
        begin
            tab_temp[b.idx] = b.temp;
            tab_pwm[b.idx]  = b.pwm;
            s = ST_LOADED;
        end
        else
        begin
            n  = (used_points > TABLE_SLOTS) ? TABLE_SLOTS : int'(used_points);
            sv = b.sp;
            if (n == 0)
                s = ST_EMPTY;
            else if (sv <= tab_temp[0])
            begin
                p = tab_pwm[0];
                s = ST_BELOW;
            end
            else if (sv >= tab_temp[n-1])
            begin
                p = tab_pwm[n-1];
                s = ST_ABOVE;
            end
            else
            begin
                s   = ST_NOSEG;
                hit = 1'b0;
                // take the first segment that brackets the setpoint
                for (int i = 0; i + 1 < n; i++)
                begin
                    if (!hit && sv >= tab_temp[i] && sv <= tab_temp[i+1])
                    begin
                        hit = 1'b1;
                        x1 = tab_temp[i];
                        x2 = tab_temp[i+1];
                        y1 = tab_pwm[i];
                        y2 = tab_pwm[i+1];
                        if (x2 == x1)
                            v = y1;
                        else
                            v = (sv - x1) * (y2 - y1) / (x2 - x1) + y1;
                        if (v < floor_lim)
                            v = floor_lim;
                        else if (v > ceil_lim)
                            v = ceil_lim;
                        p = v[DATA_W-1:0];
                        s = ST_INTERP;
                    end
                end
            end
        end
    endfunction

    function automatic int clip16(input int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int draw_gap();
        return calm_sender ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic void push_load(input int idx, input int temp, input int pwm);
        job_t j;
        j.kind         = JOB_BEAT;
        j.beat.command = CMD_LOAD;
        j.beat.idx     = idx[INDEX_W-1:0];
        j.beat.temp    = temp[DATA_W-1:0];
        j.beat.pwm     = pwm[DATA_W-1:0];
        j.beat.sp      = DATA_W'($urandom_range(0, 65535));
        j.gap          = draw_gap();
        pending_jobs.push_back(j);
        plan_temp[idx] = temp;
        beats_queued++;
    endfunction

    function automatic void push_eval(input int sp);
        job_t j;
        j.kind         = JOB_BEAT;
        j.beat.command = CMD_EVAL;
        j.beat.idx     = INDEX_W'($urandom_range(0, 15));
        j.beat.temp    = DATA_W'($urandom_range(0, 65535));
        j.beat.pwm     = DATA_W'($urandom_range(0, 65535));
        j.beat.sp      = sp[DATA_W-1:0];
        j.gap          = draw_gap();
        pending_jobs.push_back(j);
        beats_queued++;
    endfunction

    function automatic void push_cfg(input cfg_index_t r, input int d);
        job_t j;
        j.kind    = JOB_CFG;
        j.reg_sel = r;
        j.data    = d[DATA_W-1:0];
        j.gap     = draw_gap();
        pending_jobs.push_back(j);
        if (r == CFG_POINT_COUNT)
            plan_points = (d[COUNT_W-1:0] > TABLE_SLOTS) ? TABLE_SLOTS : d[COUNT_W-1:0];
    endfunction

    // Mostly around the used span of the table, sometimes on a breakpoint or anywhere
    function automatic int pick_setpoint();
        int lo, hi, r;
        if (plan_points == 0)
            return $urandom_range(0, 65535) - 32768;
        lo = plan_temp[0];
        hi = lo;
        for (int i = 1; i < plan_points; i++)
        begin
            if (plan_temp[i] < lo) lo = plan_temp[i];
            if (plan_temp[i] > hi) hi = plan_temp[i];
        end
        r = $urandom_range(0, 19);
        if (r < 3)
            return $urandom_range(0, 65535) - 32768;
        if (r < 6)
            return plan_temp[$urandom_range(0, plan_points - 1)];
        return clip16(lo - 20 + $urandom_range(0, hi - lo + 40));
    endfunction

    // Fill every slot with ascending temperatures, wide or tightly spaced
    function automatic void load_sorted_table();
        bit narrow;
        int t;
        narrow = ($urandom_range(0, 1) == 1);
        t = narrow ? $urandom_range(0, 59000) - 30000 : $urandom_range(0, 2000) - 32768;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            push_load(i, t, $urandom_range(0, 65535) - 32768);
            t = clip16(t + (narrow ? $urandom_range(0, 60) : $urandom_range(0, 4400)));
        end
    endfunction

    // Drive beats and register writes from the pending queue
    always @(negedge clk)
    begin : drive_inputs
        logic next_valid;
        logic next_we;
        next_valid = in_ch.valid;
        next_we    = 1'b0;
        if (!rst_n)
            next_valid = 1'b0;
        else
        begin
            // drop the beat taken at the last rising edge
            if (in_ch.valid && in_took)
                next_valid = 1'b0;
            if (!job_active && pending_jobs.size() != 0)
            begin
                cur_job    = pending_jobs.pop_front();
                hold_left  = cur_job.gap;
                job_active = 1'b1;
            end
            if (job_active && !next_valid)
            begin
                if (hold_left > 0)
                    hold_left--;
                else
                begin
                    case (cur_job.kind)
                        JOB_BEAT:
                        begin
                            in_ch.command           <= cur_job.beat.command;
                            in_ch.point_index       <= cur_job.beat.idx;
                            in_ch.point_temperature <= cur_job.beat.temp;
                            in_ch.point_pwm         <= cur_job.beat.pwm;
                            in_ch.setpoint          <= cur_job.beat.sp;
                            next_valid = 1'b1;
                            job_active = 1'b0;
                        end
                        JOB_CFG:
                        begin
                            // write only once the block has handed back every result
                            if (expected_drive.size() == 0)
                            begin
                                cfg_index  <= cur_job.reg_sel;
                                cfg_data   <= cur_job.data;
                                next_we    = 1'b1;
                                job_active = 1'b0;
                            end
                        end
                        default:
                        begin
                            job_active = 1'b0;
                        end
                    endcase
                end
            end
        end
        in_ch.valid <= next_valid;
        cfg_we      <= next_we;
    end

    // Stall the result side for a random count after each beat, with calm stretches
    always @(negedge clk)
    begin : drive_ready
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_took)
                stall_left = ((results_seen / 80) % 3 == 2) ? 0 : $urandom_range(0, 19);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Track register writes, predict accepted beats and check result beats
    always @(posedge clk)
    begin : watch_ports
        beat_t                    seen;
        drive_t                   want;
        logic signed [DATA_W-1:0] p;
        status_t                  s;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                cfg_writes++;
                case (cfg_index)
                    CFG_POINT_COUNT: used_points = cfg_data[COUNT_W-1:0];
                    CFG_PWM_FLOOR:   floor_lim   = cfg_data;
                    CFG_PWM_CEILING: ceil_lim    = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen.command = in_ch.command;
                seen.idx     = in_ch.point_index;
                seen.temp    = in_ch.point_temperature;
                seen.pwm     = in_ch.point_pwm;
                seen.sp      = in_ch.setpoint;
                predict_drive(seen, p, s);
                want.pwm    = p;
                want.status = s;
                expected_drive.push_back(want);
                status_hits[s]++;
                beats_accepted++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_drive.size() == 0)
                    report_mismatch("result beat with nothing pending");
                else
                begin
                    want = expected_drive.pop_front();
                    if (out_ch.pwm !== want.pwm)
                        report_mismatch($sformatf("result %0d pwm %0d, predicted %0d",
                                                  results_seen, out_ch.pwm, want.pwm));
                    if (out_ch.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                                  results_seen, out_ch.status, want.status));
                end
            end
        end
        in_took  <= rst_n && in_ch.valid && in_ch.ready;
        out_took <= rst_n && out_ch.valid && out_ch.ready;
    end

    // Stimulus plan, reset and end of run
    initial
    begin : stimulus
        int phase;
        int count;
        int mode;
        int lo;
        int hi;
        int slot;
        in_ch.valid             = 1'b0;
        in_ch.command           = CMD_LOAD;
        in_ch.point_index       = '0;
        in_ch.point_temperature = '0;
        in_ch.point_pwm         = '0;
        in_ch.setpoint          = '0;
        out_ch.ready            = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_POINT_COUNT;
        cfg_data                = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tab_temp[i]  = '0;
            tab_pwm[i]   = '0;
            plan_temp[i] = 0;
        end

        // empty table straight out of reset
        push_eval(-32768);
        push_eval(32767);
        // short table with extreme corners and a pair of equal temperatures
        push_load(0, -32768, -32768);
        push_load(1, 0, 0);
        push_load(2, 0, 900);
        push_load(3, 1000, -500);
        push_load(4, 32767, 32767);
        push_cfg(CFG_POINT_COUNT, 5);
        push_cfg(CFG_PWM_FLOOR, -32768);
        push_cfg(CFG_PWM_CEILING, 32767);
        push_eval(-32768);
        push_eval(32767);
        push_eval(-32767);
        push_eval(-1);
        push_eval(0);
        push_eval(1);
        push_eval(999);
        push_eval(1001);
        // clamp against the reset limits
        push_cfg(CFG_PWM_FLOOR, 0);
        push_cfg(CFG_PWM_CEILING, 1000);
        push_eval(-16384);
        push_eval(500);
        push_eval(999);
        // floor above ceiling
        push_cfg(CFG_PWM_FLOOR, 500);
        push_cfg(CFG_PWM_CEILING, 100);
        push_eval(-16384);
        push_eval(1);
        // a single point: below or above only
        push_cfg(CFG_POINT_COUNT, 1);
        push_eval(-32768);
        push_eval(5);

        // random phases: fresh register settings, mostly evaluations over a sorted table
        phase = 0;
        while (beats_queued < 1200)
        begin
            calm_sender = (phase % 4 == 3);
            if (phase % 2 == 0)
                load_sorted_table();
            mode = $urandom_range(0, 9);
            case (mode)
                0:       count = 0;
                1:       count = 1;
                2:       count = $urandom_range(17, 31);
                3:       count = 16;
                default: count = $urandom_range(2, 16);
            endcase
            push_cfg(CFG_POINT_COUNT, ($urandom_range(0, 2047) << COUNT_W) | count);
            mode = $urandom_range(0, 5);
            case (mode)
                0:
                begin
                    lo = -32768;
                    hi = 32767;
                end
                1:
                begin
                    hi = $urandom_range(0, 65534) - 32768;
                    lo = hi + 1 + $urandom_range(0, 32767 - hi - 1);
                end
                2:
                begin
                    lo = 0;
                    hi = 1000;
                end
                default:
                begin
                    lo = $urandom_range(0, 65535) - 32768;
                    hi = lo + $urandom_range(0, 32767 - lo);
                end
            endcase
            push_cfg(CFG_PWM_FLOOR, lo);
            push_cfg(CFG_PWM_CEILING, hi);
            repeat ($urandom_range(40, 90))
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    slot = $urandom_range(0, TABLE_SLOTS - 1);
                    if ($urandom_range(0, 1))
                        push_load(slot, $urandom_range(0, 65535) - 32768,
                                  $urandom_range(0, 65535) - 32768);
                    else
                        push_load(slot, clip16(plan_temp[slot] + $urandom_range(0, 400) - 200),
                                  $urandom_range(0, 65535) - 32768);
                end
                else
                    push_eval(pick_setpoint());
            end
            phase++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hold until every beat is taken and every result has come back
        while (beats_accepted < beats_queued || expected_drive.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d loads, %0d register writes and %0d evaluations",
                 status_hits[ST_LOADED], cfg_writes, beats_accepted - status_hits[ST_LOADED]);
        $display("Evaluations: %0d interpolated, %0d below, %0d above, %0d empty, %0d no segment",
                 status_hits[ST_INTERP], status_hits[ST_BELOW], status_hits[ST_ABOVE],
                 status_hits[ST_EMPTY], status_hits[ST_NOSEG]);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Abandon a hung run
    initial
    begin : watchdog
        #5ms;
        $display("Timeout with %0d beats accepted of %0d", beats_accepted, beats_queued);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/plff_pkg.sv
sv/plff_in_if.sv
sv/plff_out_if.sv
sv/plff_cfg.sv
sv/plff_div.sv
sv/plff_ctrl.sv
sv/plff_dp.sv
sv/piecewise_linear_feedforward_unit.sv
sv/plff_checker.sv
test/piecewise_linear_feedforward_unit_tb.sv
